// ===== rtl/core/pidc_pkg.sv =====
// Shared types, constants and helpers for the clamped PID controller.
// Used by the channel interfaces and by every module under rtl/core.
`default_nettype none

package pidc_pkg;

  // Default sizes of the sample and integral words
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF    = 40;

  // Fixed field widths
  localparam int GAIN_W     = 16;  // Q8.8 gains
  localparam int LIM_W      = 16;  // integer drive limits
  localparam int DT_W       = 16;  // Q4.12 time step
  localparam int DT_FRAC    = 12;
  localparam int OUT_FRAC   = 20;  // output sum is Q.20
  localparam int HIT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WIDE_W     = 32;  // widest sample word

  // Terms and sums saturate at +-2^SAT_EXP; the datapath needs room for a sum of two
  localparam int SAT_EXP  = 62;
  localparam int SAT_BITS = SAT_EXP + 3;

  // Item kinds
  localparam logic KIND_CLEAR = 1'b1;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_DRIVE_MAX = 3'd3,
    REG_DRIVE_MIN = 3'd4
  } cfg_reg_t;

  // Clamp status codes
  typedef enum logic [HIT_W-1:0] {
    HIT_NONE = 2'd0,
    HIT_MAX  = 2'd1,
    HIT_MIN  = 2'd2
  } hit_t;

  // Configuration handed from the register file to the sequencer
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [LIM_W-1:0]  drive_max;
    logic signed [LIM_W-1:0]  drive_min;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:    '0,
    gain_i:    '0,
    gain_d:    '0,
    drive_max: 16'sh7FFF,
    drive_min: 16'sh8000
  };

  // Width of the shared datapath: products, integral sum and saturated sums must fit
  function automatic int acc_width(input int sample_w, input int sum_w);
    int w;
    w = SAT_BITS;
    if (sum_w + GAIN_W + 1 > w) w = sum_w + GAIN_W + 1;
    if (sample_w + GAIN_W + 2 + DT_FRAC + 1 > w) w = sample_w + GAIN_W + 2 + DT_FRAC + 1;
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pidc_ifs.sv =====
// Valid/ready channel interfaces of the PID controller: command, result, config.
// Depends on pidc_pkg for field widths.
`default_nettype none

interface pidc_cmd_if
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic        [DT_W-1:0]         dt_step;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, kind, dt_step, setpoint, measured, input ready);
  modport sink   (input valid, kind, dt_step, setpoint, measured, output ready);
endinterface

interface pidc_res_if
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] drive;
  logic        [HIT_W-1:0]        limit_hit;

  modport source (output valid, drive, limit_hit, input ready);
  modport sink   (input valid, drive, limit_hit, output ready);
endinterface

interface pidc_cfg_if
  import pidc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pidc_alu.sv =====
// Shared add/subtract unit of the PID datapath.
// Depends on pidc_pkg for the default width.
`default_nettype none

module pidc_alu
  import pidc_pkg::*;
#(
  parameter int WIDTH = SAT_BITS
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] y
);

  // y = a + b, or a - b when sub is set
  assign y = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule

`default_nettype wire

// ===== rtl/core/pidc_regs.sv =====
// Configuration register file: gains and drive limits.
// Depends on pidc_pkg for the register map and cfg_t.
`default_nettype none

module pidc_regs
  import pidc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Writes are always accepted
  assign wr_ready = 1'b1;

  // Register decode; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_valid) begin
      case (cfg_reg_t'(wr_index))
        REG_GAIN_P:    cfg.gain_p    <= wr_data;
        REG_GAIN_I:    cfg.gain_i    <= wr_data;
        REG_GAIN_D:    cfg.gain_d    <= wr_data;
        REG_DRIVE_MAX: cfg.drive_max <= wr_data;
        REG_DRIVE_MIN: cfg.drive_min <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pidc_seq.sv =====
// Sequencer and working registers of the PID step: multiplies by shift-add,
// divides by restoring steps, all through the shared pidc_alu. Depends on pidc_pkg.
`default_nettype none

module pidc_seq
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF,
  parameter int ACC_W        = acc_width(SAMPLE_WIDTH, SUM_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  // command side
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  logic                           cmd_kind,
  input  logic        [DT_W-1:0]         cmd_dt_step,
  input  logic signed [SAMPLE_WIDTH-1:0] cmd_setpoint,
  input  logic signed [SAMPLE_WIDTH-1:0] cmd_measured,
  // result side
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic signed [SAMPLE_WIDTH-1:0] res_drive,
  output logic        [HIT_W-1:0]        res_limit_hit,
  // shared unit
  output logic        [ACC_W-1:0]        alu_a,
  output logic        [ACC_W-1:0]        alu_b,
  output logic                           alu_sub,
  input  logic        [ACC_W-1:0]        alu_y
);

  localparam int ERR_W  = SAMPLE_WIDTH + 1;
  localparam int DIFF_W = SAMPLE_WIDTH + 2;
  localparam int MAG_W  = SAMPLE_WIDTH + GAIN_W + 1;  // |gain_d * diff|
  localparam int NUM_W  = MAG_W + DT_FRAC;            // dividend and quotient
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int BCNT_W = $clog2(GAIN_W);
  localparam logic [BCNT_W-1:0] BCNT_TOP = BCNT_W'(GAIN_W - 1);
  localparam logic [DCNT_W-1:0] DCNT_TOP = DCNT_W'(NUM_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(1) << SAT_EXP;
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
  localparam logic [ACC_W-1:0] Q_SAT = ACC_W'(1) << (SAT_EXP - DT_FRAC);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_DIFF, S_MUL_E, S_INTEG, S_MUL_P, S_P_LOAD, S_MUL_I, S_I_CLIP,
    S_I_ADD, S_MUL_D, S_D_ABS, S_DIV, S_D_FIX, S_D_ADD, S_LIM_HI, S_LIM_LO
  } state_t;

  state_t state;

  // item and controller state
  logic        [DT_W-1:0]         dt_r;
  logic signed [SAMPLE_WIDTH-1:0] sp_r;
  logic signed [SAMPLE_WIDTH-1:0] ms_r;
  logic signed [ERR_W-1:0]        err_r;
  logic signed [DIFF_W-1:0]       diff_r;
  logic signed [ERR_W-1:0]        last_error;
  logic signed [SUM_WIDTH-1:0]    error_sum;

  // working registers
  logic [ACC_W-1:0]  work;
  logic [ACC_W-1:0]  total;
  logic [BCNT_W-1:0] bcnt;
  logic [NUM_W-1:0]  num;
  logic [DT_W-1:0]   rem;
  logic [DCNT_W-1:0] dcnt;
  logic              neg_d;

  // sign-extended operands
  logic [ACC_W-1:0] sp_x, ms_x, err_x, last_x, diff_x, sum_x, dmax_x, dmin_x;
  logic [WIDE_W-1:0] dmax_w, dmin_w;

  assign sp_x   = {{(ACC_W-SAMPLE_WIDTH){sp_r[SAMPLE_WIDTH-1]}}, sp_r};
  assign ms_x   = {{(ACC_W-SAMPLE_WIDTH){ms_r[SAMPLE_WIDTH-1]}}, ms_r};
  assign err_x  = {{(ACC_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign last_x = {{(ACC_W-ERR_W){last_error[ERR_W-1]}}, last_error};
  assign diff_x = {{(ACC_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r};
  assign sum_x  = {{(ACC_W-SUM_WIDTH){error_sum[SUM_WIDTH-1]}}, error_sum};
  assign dmax_x = {{(ACC_W-LIM_W-OUT_FRAC){cfg.drive_max[LIM_W-1]}}, cfg.drive_max,
                   {OUT_FRAC{1'b0}}};
  assign dmin_x = {{(ACC_W-LIM_W-OUT_FRAC){cfg.drive_min[LIM_W-1]}}, cfg.drive_min,
                   {OUT_FRAC{1'b0}}};
  assign dmax_w = {{(WIDE_W-LIM_W){cfg.drive_max[LIM_W-1]}}, cfg.drive_max};
  assign dmin_w = {{(WIDE_W-LIM_W){cfg.drive_min[LIM_W-1]}}, cfg.drive_min};

  // saturate to +-2^62
  function automatic logic [ACC_W-1:0] clip(input logic [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v;
    if (s > SAT_HI) return SAT_HI;
    else if (s < SAT_LO) return SAT_LO;
    else return v;
  endfunction

  // multiplier operand select
  logic [ACC_W-1:0]  mcand;
  logic [GAIN_W-1:0] mplier;
  logic              msigned;
  logic              mbit;
  logic              mfirst;
  logic [ACC_W-1:0]  work_sh;

  always_comb begin
    case (state)
      S_MUL_E: begin
        mcand = err_x;  mplier = dt_r;       msigned = 1'b0;
      end
      S_MUL_P: begin
        mcand = err_x;  mplier = cfg.gain_p; msigned = 1'b1;
      end
      S_MUL_I: begin
        mcand = sum_x;  mplier = cfg.gain_i; msigned = 1'b1;
      end
      default: begin
        mcand = diff_x; mplier = cfg.gain_d; msigned = 1'b1;
      end
    endcase
  end

  assign mbit    = mplier[bcnt];
  assign mfirst  = (bcnt == BCNT_TOP);
  assign work_sh = mfirst ? '0 : {work[ACC_W-2:0], 1'b0};

  // divider step and quotient post-processing
  logic [DT_W:0]    div_sh;
  logic             div_ge;
  logic [ACC_W-1:0] q_x;
  logic [ACC_W-1:0] q_mag;

  assign div_sh = {rem, num[NUM_W-1]};
  assign div_ge = ~alu_y[ACC_W-1];
  assign q_x    = {{(ACC_W-NUM_W){1'b0}}, num};
  assign q_mag  = (q_x > Q_SAT) ? SAT_HI : (q_x << DT_FRAC);

  // shared unit operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_ERR: begin
        alu_a = sp_x; alu_b = ms_x; alu_sub = 1'b1;
      end
      S_DIFF: begin
        alu_a = err_x; alu_b = last_x; alu_sub = 1'b1;
      end
      S_MUL_E, S_MUL_P, S_MUL_I, S_MUL_D: begin
        alu_a   = work_sh;
        alu_b   = mbit ? mcand : '0;
        alu_sub = mbit & mfirst & msigned;  // sign bit of a signed multiplier weighs negative
      end
      S_INTEG: begin
        alu_a = sum_x; alu_b = work;
      end
      S_I_ADD, S_D_ADD: begin
        alu_a = total; alu_b = work;
      end
      S_D_ABS: begin
        alu_a = '0; alu_b = work; alu_sub = work[ACC_W-1];
      end
      S_DIV: begin
        alu_a = {{(ACC_W-DT_W-1){1'b0}}, div_sh};
        alu_b = {{(ACC_W-DT_W){1'b0}}, dt_r};
        alu_sub = 1'b1;
      end
      S_D_FIX: begin
        alu_a = '0; alu_b = q_mag; alu_sub = neg_d;
      end
      S_LIM_HI: begin
        alu_a = dmax_x; alu_b = total; alu_sub = 1'b1;
      end
      S_LIM_LO: begin
        alu_a = total; alu_b = dmin_x; alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // integral saturation to the SUM_WIDTH range
  logic sum_ovf;
  assign sum_ovf = (alu_y[ACC_W-1:SUM_WIDTH-1] != {(ACC_W-SUM_WIDTH+1){alu_y[ACC_W-1]}});

  logic out_free;
  assign out_free  = ~res_valid | res_ready;
  assign cmd_ready = (state == S_IDLE);

  // a result word is loaded into the output register this cycle
  logic res_load;
  assign res_load = out_free &&
                    (((state == S_LIM_HI) && alu_y[ACC_W-1]) || (state == S_LIM_LO));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
      bcnt       <= BCNT_TOP;
      dcnt       <= DCNT_TOP;
    end else begin
      if (res_valid && res_ready && !res_load) res_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd_kind == KIND_CLEAR) begin
              error_sum  <= '0;
              last_error <= '0;
            end else begin
              dt_r  <= cmd_dt_step;
              sp_r  <= cmd_setpoint;
              ms_r  <= cmd_measured;
              state <= S_ERR;
            end
          end
        end
        S_ERR: begin
          err_r <= alu_y[ERR_W-1:0];
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff_r     <= alu_y[DIFF_W-1:0];
          last_error <= err_r;
          state      <= S_MUL_E;
        end
        S_MUL_E, S_MUL_P, S_MUL_I, S_MUL_D: begin
          work <= alu_y;
          if (bcnt == '0) begin
            bcnt <= BCNT_TOP;
            case (state)
              S_MUL_E: state <= S_INTEG;
              S_MUL_P: state <= S_P_LOAD;
              S_MUL_I: state <= S_I_CLIP;
              default: state <= S_D_ABS;
            endcase
          end else begin
            bcnt <= bcnt - 1'b1;
          end
        end
        S_INTEG: begin
          if (sum_ovf) error_sum <= alu_y[ACC_W-1] ? SUM_MIN : SUM_MAX;
          else         error_sum <= alu_y[SUM_WIDTH-1:0];
          state <= S_MUL_P;
        end
        S_P_LOAD: begin
          total <= clip(work << DT_FRAC);
          state <= S_MUL_I;
        end
        S_I_CLIP: begin
          work  <= clip(work);
          state <= S_I_ADD;
        end
        S_I_ADD: begin
          total <= clip(alu_y);
          state <= (dt_r == '0) ? S_LIM_HI : S_MUL_D;
        end
        S_D_ABS: begin
          num   <= {alu_y[MAG_W-1:0], {DT_FRAC{1'b0}}};
          rem   <= '0;
          neg_d <= work[ACC_W-1];
          dcnt  <= DCNT_TOP;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= div_ge ? alu_y[DT_W-1:0] : div_sh[DT_W-1:0];
          num <= {num[NUM_W-2:0], div_ge};
          if (dcnt == '0) state <= S_D_FIX;
          else            dcnt  <= dcnt - 1'b1;
        end
        S_D_FIX: begin
          work  <= alu_y;
          state <= S_D_ADD;
        end
        S_D_ADD: begin
          total <= clip(alu_y);
          state <= S_LIM_HI;
        end
        S_LIM_HI: begin
          if (alu_y[ACC_W-1]) begin
            // sum above the upper limit
            if (out_free) begin
              res_drive     <= dmax_w[SAMPLE_WIDTH-1:0];
              res_limit_hit <= HIT_MAX;
              res_valid     <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_LIM_LO;
          end
        end
        S_LIM_LO: begin
          if (out_free) begin
            if (alu_y[ACC_W-1]) begin
              res_drive     <= dmin_w[SAMPLE_WIDTH-1:0];
              res_limit_hit <= HIT_MIN;
            end else begin
              res_drive     <= total[OUT_FRAC +: SAMPLE_WIDTH];  // floor of Q.20
              res_limit_hit <= HIT_NONE;
            end
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pid_controller_clamped_top.sv =====
// Clamped fixed-point PID controller, top level.
// A step runs four 16-step shift-add multiplies and a (SAMPLE_WIDTH+29)-step
// restoring divide through one shared adder; when dt_step is zero the derivative
// multiply and the divide are skipped, and the lower-limit check is skipped when the
// upper limit clamps; a clear is handled while idle. Items are taken one at a time.
// Reset (rst, synchronous) clears the integral, last error and config to defaults.
`default_nettype none

module pid_controller_clamped_top
  import pidc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pidc_cmd_if.sink   cmd,
  pidc_res_if.source res,
  pidc_cfg_if.sink   cfg
);

  localparam int ACC_W = acc_width(SAMPLE_WIDTH, SUM_WIDTH);

  cfg_t             cfg_q;
  logic [ACC_W-1:0] alu_a;
  logic [ACC_W-1:0] alu_b;
  logic             alu_sub;
  logic [ACC_W-1:0] alu_y;

  // configuration registers
  pidc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // shared arithmetic unit
  pidc_alu #(
    .WIDTH (ACC_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  // step sequencer
  pidc_seq #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH),
    .ACC_W        (ACC_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_q),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_kind      (cmd.kind),
    .cmd_dt_step   (cmd.dt_step),
    .cmd_setpoint  (cmd.setpoint),
    .cmd_measured  (cmd.measured),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_drive     (res.drive),
    .res_limit_hit (res.limit_hit),
    .alu_a         (alu_a),
    .alu_b         (alu_b),
    .alu_sub       (alu_sub),
    .alu_y         (alu_y)
  );

endmodule

`default_nettype wire
